// ===== rtl/bcmp_pkg.sv =====
// ----------------------------------------------------------------------------
// bcmp_pkg: shared types and constants
// Beat formats, the prime modulus and Barrett constants for the
// binomial coefficient block.
// ----------------------------------------------------------------------------
`default_nettype none
package bcmp_pkg;

  localparam int unsigned CNT_W     = 13;
  localparam int unsigned VAL_W     = 30;
  localparam int unsigned ADDR_MAX_W = 20;

  localparam logic [63:0] P_WIDE    = 64'd1000000007;
  localparam logic [VAL_W-1:0] P_MOD = VAL_W'(P_WIDE);
  // Barrett constant floor(2^60 / P).
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / P_WIDE);
  // Fermat exponent P - 2.
  localparam logic [VAL_W-1:0] FERMAT_EXP = VAL_W'(P_WIDE - 64'd2);

  localparam int unsigned MM_LAT    = 4;
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 16;

  typedef struct packed {
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] chosen_count;
  } in_beat_t;

  typedef struct packed {
    logic [VAL_W-1:0] coefficient;
    logic             invalid_query;
  } out_beat_t;

  typedef struct packed {
    logic             invalid;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] chosen;
    logic [CNT_W-1:0] diff;
  } mid_item_t;

  typedef struct packed {
    logic                  we;
    logic                  sel_ifac;
    logic [ADDR_MAX_W-1:0] addr;
    logic [VAL_W-1:0]      data;
  } table_wr_t;

endpackage
`default_nettype wire

// ===== rtl/binomial_coefficient_mod_prime.sv =====
// ----------------------------------------------------------------------------
// binomial_coefficient_mod_prime: C(n,m) mod 1e9+7 from factorial tables
// Front classification and queue, table build sequencer, and lookup/multiply
// back end behind a credit-controlled result queue.
// ----------------------------------------------------------------------------
// Path: from the edge that accepts a beat until its result is at the head of
// the result queue, a beat passes the queue hop, table read, two 4-stage
// modular multipliers and the result queue write.
// Throughput: one query beat per cycle while results are popped; the 16 result
// credits cover the loop from issue to the earliest pop.
// Reset: rst_n is synchronous; afterwards full stays high during the table
// build, paced by the one shared build multiplier (one product at a time,
// two table passes plus the Fermat power).
// ----------------------------------------------------------------------------
`default_nettype none
module binomial_coefficient_mod_prime import bcmp_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 8192
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           full,
  input  wire in_beat_t  in_data,
  output logic           empty,
  input  wire logic      pop,
  output out_beat_t      out_data
);

  // Front end: classify each beat as it arrives. A beat is invalid when the
  // chosen count exceeds the total, or when the total lies past the table.
  // Invalid beats still travel the back end so results stay in order.
  mid_item_t mid_in, mid_out;
  logic      mid_full, mid_empty, mid_pop;
  logic      build_done;
  table_wr_t tbl_wr;

  assign mid_in.invalid = (in_data.chosen_count > in_data.total_count) ||
                          (32'(in_data.total_count) >= TABLE_SIZE);
  assign mid_in.total   = in_data.total_count;
  assign mid_in.chosen  = in_data.chosen_count;
  assign mid_in.diff    = in_data.total_count - in_data.chosen_count;

  // Nothing is taken until both tables are complete.
  assign full = mid_full || !build_done;

  bcmp_fifo #(.W($bits(mid_item_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk(clk), .rst_n(rst_n),
    .push(push && build_done), .din(mid_in), .full(mid_full),
    .pop(mid_pop), .dout(mid_out), .empty(mid_empty)
  );

  bcmp_build #(.TABLE_SIZE(TABLE_SIZE)) u_build (
    .clk(clk), .rst_n(rst_n), .wr(tbl_wr), .done(build_done)
  );

  // Back end: reads fac[n], ifac[m] and ifac[n-m] and multiplies them.
  bcmp_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk(clk), .rst_n(rst_n), .wr(tbl_wr),
    .item(mid_out), .item_empty(mid_empty), .item_pop(mid_pop),
    .out_data(out_data), .empty(empty), .pop(pop)
  );

endmodule
`default_nettype wire

// ===== rtl/bcmp_modmul.sv =====
// ----------------------------------------------------------------------------
// bcmp_modmul: pipelined modular multiplier
// Computes a*b mod P in four stages with Barrett reduction; a tag rides along.
// ----------------------------------------------------------------------------
`default_nettype none
module bcmp_modmul import bcmp_pkg::*; #(
  parameter int unsigned TW = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [VAL_W-1:0] in_a,
  input  wire logic [VAL_W-1:0] in_b,
  input  wire logic [TW-1:0]    in_tag,
  output logic                  out_valid,
  output logic [VAL_W-1:0]      out_res,
  output logic [TW-1:0]         out_tag
);

  logic [3:0]       v_r;
  logic [TW-1:0]    tag1_r, tag2_r, tag3_r, tag4_r;
  logic [59:0]      prod1_r;
  logic [61:0]      est2_r;
  logic [31:0]      lo2_r;
  logic [31:0]      rem3_r;
  logic [VAL_W-1:0] res4_r;
  logic [30:0]      quot;
  logic [31:0]      rem_nxt;
  logic [VAL_W-1:0] res_nxt;

  assign quot    = est2_r[61:31];
  assign rem_nxt = lo2_r - 32'(quot * P_MOD);

  // The Barrett estimate is at most two short, so the remainder is below 3P.
  always_comb begin
    if (rem3_r >= 32'(2 * P_WIDE)) begin
      res_nxt = VAL_W'(rem3_r - 32'(2 * P_WIDE));
    end else if (rem3_r >= 32'(P_WIDE)) begin
      res_nxt = VAL_W'(rem3_r - 32'(P_WIDE));
    end else begin
      res_nxt = VAL_W'(rem3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
    prod1_r <= 60'(in_a) * 60'(in_b);
    tag1_r  <= in_tag;
    est2_r  <= 62'(prod1_r[59:29]) * 62'(BARRETT_MU);
    lo2_r   <= prod1_r[31:0];
    tag2_r  <= tag1_r;
    rem3_r  <= rem_nxt;
    tag3_r  <= tag2_r;
    res4_r  <= res_nxt;
    tag4_r  <= tag3_r;
  end

  assign out_valid = v_r[3];
  assign out_res   = res4_r;
  assign out_tag   = tag4_r;

endmodule
`default_nettype wire

// ===== rtl/bcmp_fifo.sv =====
// ----------------------------------------------------------------------------
// bcmp_fifo: small register queue
// Push/pop queue with full and empty flags; the head is shown combinationally.
// ----------------------------------------------------------------------------
`default_nettype none
module bcmp_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bcmp_build.sv =====
// ----------------------------------------------------------------------------
// bcmp_build: table build sequencer
// Fills the factorial table, takes the Fermat inverse of the last entry and
// walks the inverse factorial table downward, one modular product at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module bcmp_build import bcmp_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 8192
) (
  input  wire logic clk,
  input  wire logic rst_n,
  output table_wr_t wr,
  output logic      done
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

  typedef enum logic [4:0] {
    B_INIT = 5'b00001,
    B_FAC  = 5'b00010,
    B_POW  = 5'b00100,
    B_INV  = 5'b01000,
    B_DONE = 5'b10000
  } build_state_t;

  build_state_t     state_r, state_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt, base_r, base_nxt, pacc_r, pacc_nxt;
  logic [VAL_W-1:0] exp_r, exp_nxt;
  logic             phase_r, phase_nxt, busy_r, busy_nxt;
  logic             mm_v, res_v;
  logic [VAL_W-1:0] mm_a, mm_b, res;

  bcmp_modmul #(.TW(1)) u_mul (
    .clk(clk), .rst_n(rst_n),
    .in_valid(mm_v), .in_a(mm_a), .in_b(mm_b), .in_tag(1'b0),
    .out_valid(res_v), .out_res(res), .out_tag()
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    pacc_nxt  = pacc_r;
    exp_nxt   = exp_r;
    phase_nxt = phase_r;
    wr        = '0;
    mm_v      = 1'b0;
    mm_a      = acc_r;
    mm_b      = VAL_W'(idx_r);
    case (state_r)
      B_INIT: begin
        wr.we     = 1'b1;
        wr.addr   = '0;
        wr.data   = VAL_W'(1);
        acc_nxt   = VAL_W'(1);
        idx_nxt   = AW'(1);
        state_nxt = B_FAC;
      end
      B_FAC: begin
        mm_v = !busy_r;
        if (res_v) begin
          wr.we   = 1'b1;
          wr.addr = ADDR_MAX_W'(idx_r);
          wr.data = res;
          acc_nxt = res;
          if (idx_r == LAST) begin
            base_nxt  = res;
            exp_nxt   = FERMAT_EXP;
            pacc_nxt  = VAL_W'(1);
            phase_nxt = 1'b0;
            state_nxt = B_POW;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      B_POW: begin
        // Phase 0 folds the base into the result when the low exponent bit
        // is set; phase 1 squares the base and shifts the exponent.
        mm_a = phase_r ? base_r : pacc_r;
        mm_b = base_r;
        if (!busy_r) begin
          if (exp_r == '0) begin
            wr.we       = 1'b1;
            wr.sel_ifac = 1'b1;
            wr.addr     = ADDR_MAX_W'(LAST);
            wr.data     = pacc_r;
            acc_nxt     = pacc_r;
            idx_nxt     = LAST;
            state_nxt   = B_INV;
          end else if (!phase_r && !exp_r[0]) begin
            phase_nxt = 1'b1;
          end else begin
            mm_v = 1'b1;
          end
        end
        if (res_v) begin
          if (!phase_r) begin
            pacc_nxt  = res;
            phase_nxt = 1'b1;
          end else begin
            base_nxt  = res;
            exp_nxt   = exp_r >> 1;
            phase_nxt = 1'b0;
          end
        end
      end
      B_INV: begin
        mm_v = !busy_r;
        if (res_v) begin
          wr.we       = 1'b1;
          wr.sel_ifac = 1'b1;
          wr.addr     = ADDR_MAX_W'(idx_r - AW'(1));
          wr.data     = res;
          acc_nxt     = res;
          if (idx_r == AW'(1)) begin
            state_nxt = B_DONE;
          end else begin
            idx_nxt = idx_r - AW'(1);
          end
        end
      end
      B_DONE: begin
      end
      default: begin
        state_nxt = B_INIT;
      end
    endcase
    busy_nxt = mm_v || (busy_r && !res_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_INIT;
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
    end
    idx_r  <= idx_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    pacc_r <= pacc_nxt;
    exp_r  <= exp_nxt;
  end

  assign done = (state_r == B_DONE);

endmodule
`default_nettype wire

// ===== rtl/bcmp_back.sv =====
// ----------------------------------------------------------------------------
// bcmp_back: query execution
// Holds both tables, looks up three entries per query, multiplies them in two
// modular stages and queues the results; issue is gated by output credits.
// ----------------------------------------------------------------------------
`default_nettype none
module bcmp_back import bcmp_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 8192
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire table_wr_t wr,
  input  wire mid_item_t item,
  input  wire logic      item_empty,
  output logic           item_pop,
  output out_beat_t      out_data,
  output logic           empty,
  input  wire logic      pop
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

  logic [VAL_W-1:0] fac_mem  [TABLE_SIZE];
  logic [VAL_W-1:0] ifac_mem [TABLE_SIZE];
  logic [AW-1:0]    n_a, m_a, d_a, w_a;
  logic [VAL_W-1:0] fac_q_r, ifm_q_r, ifd_q_r;
  logic             v1_r, inv1_r;
  logic [CW-1:0]    cnt_r;
  logic             issue, out_full, out_take;
  logic             a_v, b_v, b_inv;
  logic [VAL_W-1:0] a_res, a_d, b_res;
  logic             a_inv;
  out_beat_t        res_beat;

  assign n_a = AW'(item.total);
  assign m_a = AW'(item.chosen);
  assign d_a = AW'(item.diff);
  assign w_a = AW'(wr.addr);

  // Credits keep the result queue from ever overflowing; the full flag is only a
  // second guard on issue.
  assign issue    = !item_empty && (cnt_r < CW'(OUT_DEPTH)) && !out_full;
  assign item_pop = issue;
  assign out_take = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr.we && !wr.sel_ifac) begin
      fac_mem[w_a] <= wr.data;
    end
    fac_q_r <= fac_mem[n_a];
  end

  always_ff @(posedge clk) begin
    if (wr.we && wr.sel_ifac) begin
      ifac_mem[w_a] <= wr.data;
    end
    ifm_q_r <= ifac_mem[m_a];
    ifd_q_r <= ifac_mem[d_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      v1_r  <= issue;
      cnt_r <= cnt_r + CW'(issue) - CW'(out_take);
    end
    inv1_r <= item.invalid;
  end

  bcmp_modmul #(.TW(VAL_W + 1)) u_mul_a (
    .clk(clk), .rst_n(rst_n),
    .in_valid(v1_r), .in_a(fac_q_r), .in_b(ifm_q_r), .in_tag({inv1_r, ifd_q_r}),
    .out_valid(a_v), .out_res(a_res), .out_tag({a_inv, a_d})
  );

  bcmp_modmul #(.TW(1)) u_mul_b (
    .clk(clk), .rst_n(rst_n),
    .in_valid(a_v), .in_a(a_res), .in_b(a_d), .in_tag(a_inv),
    .out_valid(b_v), .out_res(b_res), .out_tag(b_inv)
  );

  assign res_beat.coefficient   = b_inv ? '0 : b_res;
  assign res_beat.invalid_query = b_inv;

  bcmp_fifo #(.W($bits(out_beat_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(b_v), .din(res_beat), .full(out_full),
    .pop(pop), .dout(out_data), .empty(empty)
  );

endmodule
`default_nettype wire

// ===== bench/binomial_coefficient_mod_prime_test.sv =====
// ----------------------------------------------------------------------------
// binomial_coefficient_mod_prime_test: self-checking bench for C(n,m) mod P
// Builds its own factorial and inverse-factorial tables, sends directed and
// random queries with random gaps on both sides, and checks every result beat
// in order against the predicted coefficient and invalid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module binomial_coefficient_mod_prime_test;
  import bcmp_pkg::*;

  localparam int unsigned DEPTH = 8192;
  localparam longint unsigned PRIME = 64'd1000000007;
  // The build pass after reset holds full high, so the idle limit must cover it
  // with margin.
  localparam int unsigned IDLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_beat_t  in_data = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_beat_t out_data;

  always #5 clk = ~clk;

  binomial_coefficient_mod_prime u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  // Golden factorial tables, built once in the same way as the hardware.
  logic [VAL_W-1:0] fact_tab [DEPTH];
  logic [VAL_W-1:0] inv_fact_tab [DEPTH];
  out_beat_t        pending_coeffs [$];
  int unsigned      error_count = 0;
  int unsigned      sent_count = 0;
  int unsigned      checked_count = 0;
  int unsigned      invalid_count = 0;
  int unsigned      idle_cycles = 0;
  bit               sending_done = 1'b0;

  function automatic logic [VAL_W-1:0] mulmod(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    longint unsigned prod;
    prod = longint'(a) * longint'(b);
    return VAL_W'(prod % PRIME);
  endfunction

  function automatic logic [VAL_W-1:0] powmod(logic [VAL_W-1:0] base, longint unsigned ex);
    logic [VAL_W-1:0] acc;
    acc = 1;
    while (ex != 0) begin
      if (ex[0]) acc = mulmod(acc, base);
      base = mulmod(base, base);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  task automatic build_golden_tables();
    fact_tab[0] = 1;
    for (int i = 1; i < DEPTH; i++) fact_tab[i] = mulmod(fact_tab[i-1], VAL_W'(i));
    inv_fact_tab[DEPTH-1] = powmod(fact_tab[DEPTH-1], PRIME - 2);
    for (int i = DEPTH - 1; i > 0; i--) inv_fact_tab[i-1] = mulmod(inv_fact_tab[i], VAL_W'(i));
  endtask

  // Expected result beat for one query.
  function automatic out_beat_t predict_coefficient(in_beat_t q);
    out_beat_t r;
    r = '0;
    if (q.chosen_count > q.total_count || q.total_count >= DEPTH) begin
      r.invalid_query = 1'b1;
    end else begin
      r.coefficient = mulmod(mulmod(fact_tab[q.total_count], inv_fact_tab[q.chosen_count]),
                             inv_fact_tab[q.total_count - q.chosen_count]);
    end
    return r;
  endfunction

  // Sends one query beat, after a random gap when allow_gap is set; the prediction
  // is queued when the beat is accepted. Called at a falling edge.
  task automatic send_query(logic [CNT_W-1:0] n, logic [CNT_W-1:0] m, bit allow_gap = 1);
    in_beat_t q;
    int unsigned gap;
    q.total_count = n;
    q.chosen_count = m;
    gap = allow_gap ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      push <= 1'b0;
    end
    repeat (gap) @(negedge clk);
    push <= 1'b1;
    in_data <= q;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    pending_coeffs.push_back(predict_coefficient(q));
    sent_count++;
    if (q.chosen_count > q.total_count) invalid_count++;
    @(negedge clk);
  endtask

  task automatic end_burst();
    push <= 1'b0;
  endtask

  // Result side: random pops, checking each accepted beat against the oldest
  // prediction. Stretches with no stall alternate with stalled ones.
  int unsigned pop_wait = 0;
  bit          pop_burst = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_wait != 0) begin
      pop_wait <= pop_wait - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_coeffs.size() == 0) begin
        $error("result beat with no query pending: coefficient=%0d invalid_query=%0b",
               out_data.coefficient, out_data.invalid_query);
        error_count++;
      end else begin
        out_beat_t exp_beat;
        exp_beat = pending_coeffs.pop_front();
        if (out_data.coefficient !== exp_beat.coefficient) begin
          $error("coefficient: expected %0d, got %0d", exp_beat.coefficient,
                 out_data.coefficient);
          error_count++;
        end
        if (out_data.invalid_query !== exp_beat.invalid_query) begin
          $error("invalid_query: expected %0b, got %0b", exp_beat.invalid_query,
                 out_data.invalid_query);
          error_count++;
        end
      end
      checked_count++;
      if ($urandom_range(0, 3) == 0) pop_burst <= ~pop_burst;
      pop_wait <= pop_burst ? 0 : $urandom_range(0, 17);
    end
  end

  // Watchdog: counts cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results pending", idle_cycles,
               pending_coeffs.size());
      $display("binomial_coefficient_mod_prime_test: FAIL");
      $finish;
    end
  end

  // Field extremes, n equal to m, m of zero and one, top of the table.
  task automatic test_directed_extremes();
    send_query(13'd0, 13'd0);
    send_query(13'd1, 13'd0);
    send_query(13'd1, 13'd1);
    send_query(13'd8191, 13'd0);
    send_query(13'd8191, 13'd8191);
    send_query(13'd8191, 13'd1);
    send_query(13'd8191, 13'd8190);
    send_query(13'd8191, 13'd4095);
    send_query(13'd8191, 13'd4096);
    send_query(13'd4096, 13'd2048);
    send_query(13'd5461, 13'd2730);
    send_query(13'd10, 13'd3);
    end_burst();
  endtask

  // Chosen exceeds total, including both fields at their far ends.
  task automatic test_chosen_exceeds_total();
    send_query(13'd0, 13'd1);
    send_query(13'd0, 13'd8191);
    send_query(13'd8190, 13'd8191);
    send_query(13'd100, 13'd101);
    send_query(13'd2730, 13'd5461);
    send_query(13'd4095, 13'd4096);
    end_burst();
  endtask

  // Back-to-back beats with no gaps, to run the pipeline at full rate.
  task automatic test_back_to_back();
    for (int i = 0; i < 40; i++)
      send_query(CNT_W'($urandom), CNT_W'($urandom), 0);
    end_burst();
  endtask

  // Random queries: mostly valid ones with m drawn within n, plus some
  // invalid ones and raw random pairs. Gaps come in bursts.
  task automatic test_random_queries();
    logic [CNT_W-1:0] n, m;
    bit gappy;
    gappy = 1'b1;
    for (int i = 0; i < 1100; i++) begin
      if ($urandom_range(0, 19) == 0) gappy = ~gappy;
      case ($urandom_range(0, 9))
        0: begin n = CNT_W'($urandom); m = CNT_W'($urandom); end
        1: begin n = CNT_W'($urandom_range(0, 8190)); m = CNT_W'($urandom_range(n + 1, 8191)); end
        2: begin n = CNT_W'($urandom_range(0, 31)); m = CNT_W'($urandom_range(0, n)); end
        default: begin n = CNT_W'($urandom); m = CNT_W'($urandom_range(0, n)); end
      endcase
      send_query(n, m, gappy);
    end
    end_burst();
  endtask

  task automatic wait_drained();
    while (pending_coeffs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    build_golden_tables();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_extremes();
    test_chosen_exceeds_total();
    test_back_to_back();
    test_random_queries();
    wait_drained();
    $display("covered %0d queries (%0d with chosen above total), %0d results checked",
             sent_count, invalid_count, checked_count);
    $display("gaps of 0..17 cycles on both sides, with gap-free stretches");
    if (error_count == 0) begin
      $display("binomial_coefficient_mod_prime_test: PASS");
    end else begin
      $display("binomial_coefficient_mod_prime_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
